// ===== rtl/core/sbb_pkg.sv =====
package sbb_pkg;

   localparam int unsigned BIN_W  = 10;
   localparam int unsigned PART_W = 24;
   localparam int unsigned RATE_W = 18;
   localparam int unsigned COLS_W = 10;
   localparam int unsigned ROWS_W = 8;
   localparam int unsigned COL_W  = 9;
   localparam int unsigned HGT_W  = 8;
   localparam int unsigned IDX_W  = 2;
   localparam int unsigned DATA_W = RATE_W;
   localparam int unsigned FRAC_W = 8;

   localparam int unsigned MAG_W   = PART_W;
   localparam int unsigned SQ_W    = 2 * MAG_W;
   localparam int unsigned RAD_W   = SQ_W - 2 * FRAC_W;
   localparam int unsigned ROOT_W  = RAD_W / 2;
   localparam int unsigned MUL_A_W = 32;
   localparam int unsigned MUL_B_W = 24;
   localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
   localparam int unsigned LHS_W   = BIN_W + RATE_W + COL_W;
   localparam int unsigned SCL_W   = ROOT_W + ROWS_W;

   localparam int unsigned TOP_FREQ_HZ = 10000;
   localparam int unsigned FULL_SCALE  = 60;
   localparam int unsigned COL_LIMIT   = 512;
   localparam int unsigned MAX_RUN     = 16;
   localparam int unsigned RUN_W       = $clog2(MAX_RUN);

   // floor(p / 60) = floor(floor(p / 4) / 15), the second step by reciprocal
   localparam int unsigned PRE_SHIFT    = 2;
   localparam int unsigned DIV_REST     = FULL_SCALE / (1 << PRE_SHIFT);
   localparam int unsigned DIVX_W       = SCL_W - PRE_SHIFT;
   localparam int unsigned RECIP_SHIFT  = 26;
   localparam int unsigned RECIP_W      = 23;
   localparam int unsigned RECIP        = (1 << RECIP_SHIFT) / DIV_REST;
   localparam int unsigned QUO_W        = DIVX_W - 4;

   localparam int unsigned RATE_RESET = 44100;
   localparam int unsigned COLS_RESET = 512;
   localparam int unsigned ROWS_RESET = 24;

   typedef logic [BIN_W-1:0]         bin_type;
   typedef logic signed [PART_W-1:0] part_type;
   typedef logic [COL_W-1:0]         col_type;
   typedef logic [HGT_W-1:0]         hgt_type;
   typedef logic [IDX_W-1:0]         csr_idx_type;
   typedef logic [DATA_W-1:0]        csr_data_type;
   typedef logic [RAD_W-1:0]         rad_type;
   typedef logic [ROOT_W-1:0]        root_type;

   localparam csr_idx_type CSR_SAMPLE_RATE  = 2'd0;
   localparam csr_idx_type CSR_COLUMN_COUNT = 2'd1;
   localparam csr_idx_type CSR_ROW_COUNT    = 2'd2;

endpackage

// ===== rtl/core/sbb_req_if.sv =====
interface sbb_req_if;
   import sbb_pkg::*;

   logic     valid;
   logic     ready;
   bin_type  bin_number;
   part_type real_part;
   part_type imag_part;

   modport source (output valid, output bin_number, output real_part, output imag_part,
                   input ready);
   modport sink (input valid, input bin_number, input real_part, input imag_part,
                 output ready);
endinterface

// ===== rtl/core/sbb_rsp_if.sv =====
interface sbb_rsp_if;
   import sbb_pkg::*;

   logic    valid;
   logic    ready;
   col_type column_index;
   hgt_type bar_height;
   logic    last_of_run;

   modport source (output valid, output column_index, output bar_height, output last_of_run,
                   input ready);
   modport sink (input valid, input column_index, input bar_height, input last_of_run,
                 output ready);
endinterface

// ===== rtl/core/sbb_csr_if.sv =====
interface sbb_csr_if;
   import sbb_pkg::*;

   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/sbb_isqrt.sv =====
module sbb_isqrt (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  sbb_pkg::rad_type radicand,
   output sbb_pkg::root_type root,
   output logic             busy
);
   import sbb_pkg::*;

   localparam int unsigned CNT_W = $clog2(ROOT_W);

   logic [RAD_W-1:0] rem_ff, rem_in;
   logic [RAD_W-1:0] res_ff, res_in;
   logic [RAD_W-1:0] bit_ff, bit_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [RAD_W-1:0] trial;
   logic             fits;

   assign trial = res_ff + bit_ff;
   assign fits  = (rem_ff >= trial);

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = RAD_W'(1) << (RAD_W - 2);
         cnt_in  = CNT_W'(ROOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign root = res_ff[ROOT_W-1:0];
   assign busy = busy_ff;

   a_bit_onehot: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $onehot(bit_ff))
      else $error("root step bit lost");

endmodule

// ===== rtl/core/spectrum_bin_to_bar_mapper.sv =====
// Channel  Dir  Payload                                       Accept
// req_bus  in   bin_number, real_part, imag_part              valid && ready
// rsp_bus  out  column_index, bar_height, last_of_run         valid && ready
// csr_bus  in   index (0 rate, 1 columns, 2 rows), data       valid && ready
//
// An item holds the block until its column walk ends; it serves n columns (0..16).
// The square root is bit-serial in 16 steps; one shared multiplier covers the squares,
// the bin frequency products, the height scaling and the reciprocal division.
// Results leave through an output register; a stalled rsp_bus holds the walk.
// Reset: rate 44100, columns 512, rows 24, column walk at column 0.
module spectrum_bin_to_bar_mapper #(
   parameter int unsigned FFT_POINTS = 1024
) (
   input logic       clock,
   input logic       reset,
   sbb_req_if.sink   req_bus,
   sbb_rsp_if.source rsp_bus,
   sbb_csr_if.sink   csr_bus
);
   import sbb_pkg::*;

   localparam longint unsigned BASE_STEP = longint'(TOP_FREQ_HZ) * longint'(FFT_POINTS);
   localparam int unsigned BASE_W = $clog2(longint'(COL_LIMIT) * BASE_STEP + 1);
   localparam int unsigned CMP_W = (BASE_W > LHS_W) ? BASE_W : LHS_W;

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_MUL_RE    = 11'b000_0000_0010,
      ST_MUL_IM    = 11'b000_0000_0100,
      ST_ROOT_GO   = 11'b000_0000_1000,
      ST_MUL_COL   = 11'b000_0001_0000,
      ST_ROOT_WAIT = 11'b000_0010_0000,
      ST_SCALE     = 11'b000_0100_0000,
      ST_RECIP     = 11'b000_1000_0000,
      ST_FIX       = 11'b001_0000_0000,
      ST_CLAMP     = 11'b010_0000_0000,
      ST_WALK      = 11'b100_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [COLS_W-1:0] cols_ff, cols_in;
   logic [ROWS_W-1:0] rows_ff, rows_in;

   logic [BIN_W-1:0]  bin_ff, bin_in;
   logic [MAG_W-1:0]  are_ff, are_in;
   logic [MAG_W-1:0]  aim_ff, aim_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [LHS_W-1:0]  lhs_ff, lhs_in;
   logic [DIVX_W-1:0] divx_ff, divx_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [HGT_W-1:0]  hgt_ff, hgt_in;

   logic [COLS_W-1:0] next_col_ff, next_col_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [RUN_W-1:0]  run_ff, run_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [HGT_W-1:0]  rsp_hgt_ff, rsp_hgt_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [COLS_W-1:0]  cols_eff;
   logic [COL_W-1:0]   cols_m1;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  mul_p;
   logic [SQ_W-1:0]    sq_sum;
   rad_type            radicand;
   root_type           root;
   logic               root_busy;
   logic               req_take;
   logic [QUO_W-1:0]   quo_est;
   logic [DIVX_W-1:0]  quo_back;
   logic [DIVX_W-1:0]  quo_rem;
   logic [BASE_W-1:0]  base_next;
   logic [COLS_W-1:0]  next_col_inc;
   logic               col_hit;
   logic               more;
   logic               out_free;

   assign cols_eff = (cols_ff > COLS_W'(COL_LIMIT)) ? COLS_W'(COL_LIMIT) : cols_ff;
   assign cols_m1  = COL_W'(cols_eff - COLS_W'(1));

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_RE: begin
            mul_a = MUL_A_W'(are_ff);
            mul_b = MUL_B_W'(are_ff);
         end
         ST_MUL_IM: begin
            mul_a = MUL_A_W'(aim_ff);
            mul_b = MUL_B_W'(aim_ff);
         end
         ST_ROOT_GO: begin
            mul_a = MUL_A_W'(rate_ff);
            mul_b = MUL_B_W'(bin_ff);
         end
         ST_MUL_COL: begin
            mul_a = MUL_A_W'(prod_ff[BIN_W+RATE_W-1:0]);
            mul_b = MUL_B_W'(cols_m1);
         end
         ST_SCALE: begin
            mul_a = MUL_A_W'(root);
            mul_b = MUL_B_W'(rows_ff);
         end
         ST_RECIP: begin
            mul_a = MUL_A_W'(prod_ff[SCL_W-1:PRE_SHIFT]);
            mul_b = MUL_B_W'(RECIP_W'(RECIP));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign sq_sum   = sq_ff + prod_ff[SQ_W-1:0];
   assign radicand = sq_sum[SQ_W-1:SQ_W-RAD_W];

   sbb_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_ROOT_GO),
      .radicand (radicand),
      .root     (root),
      .busy     (root_busy)
   );

   assign quo_est  = prod_ff[RECIP_SHIFT +: QUO_W];
   assign quo_back = {quo_est, 4'b0000} - {4'b0000, quo_est};
   assign quo_rem  = divx_ff - quo_back;

   assign base_next    = base_ff + BASE_W'(BASE_STEP);
   assign next_col_inc = next_col_ff + COLS_W'(1);
   assign col_hit      = (next_col_ff < cols_eff) && (CMP_W'(lhs_ff) >= CMP_W'(base_ff));
   assign more         = (run_ff != RUN_W'(MAX_RUN - 1)) && (next_col_inc < cols_eff)
                         && (CMP_W'(lhs_ff) >= CMP_W'(base_next));
   assign out_free     = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rate_in = rate_ff;
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_SAMPLE_RATE:  rate_in = csr_bus.data[RATE_W-1:0];
            CSR_COLUMN_COUNT: cols_in = csr_bus.data[COLS_W-1:0];
            CSR_ROW_COUNT:    rows_in = csr_bus.data[ROWS_W-1:0];
            default: begin
               rate_in = rate_ff;
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      are_in       = are_ff;
      aim_in       = aim_ff;
      prod_in      = prod_ff;
      sq_in        = sq_ff;
      lhs_in       = lhs_ff;
      divx_in      = divx_ff;
      quo_in       = quo_ff;
      hgt_in       = hgt_ff;
      next_col_in  = next_col_ff;
      base_in      = base_ff;
      run_in       = run_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_col_in   = rsp_col_ff;
      rsp_hgt_in   = rsp_hgt_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               bin_in = req_bus.bin_number;
               are_in = req_bus.real_part[PART_W-1] ? MAG_W'(-req_bus.real_part)
                                                    : MAG_W'(req_bus.real_part);
               aim_in = req_bus.imag_part[PART_W-1] ? MAG_W'(-req_bus.imag_part)
                                                    : MAG_W'(req_bus.imag_part);
               run_in = '0;
               if (req_bus.bin_number == '0) begin
                  next_col_in = '0;
                  base_in     = '0;
               end
               state_in = ST_MUL_RE;
            end
         end
         ST_MUL_RE: begin
            prod_in  = mul_p;
            state_in = ST_MUL_IM;
         end
         ST_MUL_IM: begin
            sq_in    = prod_ff[SQ_W-1:0];
            prod_in  = mul_p;
            state_in = ST_ROOT_GO;
         end
         ST_ROOT_GO: begin
            prod_in  = mul_p;
            state_in = ST_MUL_COL;
         end
         ST_MUL_COL: begin
            prod_in  = mul_p;
            state_in = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            lhs_in = prod_ff[LHS_W-1:0];
            if (!root_busy) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            prod_in  = mul_p;
            state_in = ST_RECIP;
         end
         ST_RECIP: begin
            divx_in  = prod_ff[SCL_W-1:PRE_SHIFT];
            prod_in  = mul_p;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            quo_in   = quo_est + QUO_W'(quo_rem >= DIVX_W'(DIV_REST));
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            hgt_in   = (quo_ff > QUO_W'(rows_ff)) ? rows_ff : quo_ff[HGT_W-1:0];
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (!col_hit) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = next_col_ff[COL_W-1:0];
               rsp_hgt_in   = hgt_ff;
               rsp_last_in  = !more;
               next_col_in  = next_col_inc;
               base_in      = base_next;
               run_in       = run_ff + RUN_W'(1);
               if (!more) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bin_ff     <= bin_in;
      are_ff     <= are_in;
      aim_ff     <= aim_in;
      prod_ff    <= prod_in;
      sq_ff      <= sq_in;
      lhs_ff     <= lhs_in;
      divx_ff    <= divx_in;
      quo_ff     <= quo_in;
      hgt_ff     <= hgt_in;
      rsp_col_ff <= rsp_col_in;
      rsp_hgt_ff <= rsp_hgt_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= RATE_W'(RATE_RESET);
         cols_ff      <= COLS_W'(COLS_RESET);
         rows_ff      <= ROWS_W'(ROWS_RESET);
         next_col_ff  <= '0;
         base_ff      <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         next_col_ff  <= next_col_in;
         base_ff      <= base_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.column_index = rsp_col_ff;
   assign rsp_bus.bar_height   = rsp_hgt_ff;
   assign rsp_bus.last_of_run  = rsp_last_ff;

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (COLS_W'(rsp_col_ff) < cols_eff))
      else $error("column beyond column count");

   a_bin_zero_restart: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_bus.bin_number == '0)) |=> ((next_col_ff == '0) && (base_ff == '0)))
      else $error("bin zero did not restart walk");

   a_base_tracks_col: assert property (@(posedge clock) disable iff (reset)
      base_ff == BASE_W'(BASE_W'(next_col_ff) * BASE_W'(BASE_STEP)))
      else $error("column threshold out of step");

   a_idle_root_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !root_busy)
      else $error("square root busy while idle");

endmodule
